@@ hw/rtl/pjt_pkg.sv @@
// pjt_pkg: shared types and constants of the PTS jump tracker.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pjt_pkg;

    localparam int PTS_BITS   = 33;
    localparam int BURST_BITS = 20;
    localparam int OUT_BITS   = 34;
    localparam int APB_DBITS  = 64;
    localparam int APB_ABITS  = 5;

    // 90 kHz ticks: 2.5 s jump limit, 0.5 s burst lead
    localparam logic [PTS_BITS-1:0]   JUMP_LIMIT_RST = PTS_BITS'(5 * 90000 / 2);
    localparam logic [BURST_BITS-1:0] BURST_TIME_RST = BURST_BITS'(45000);

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_JUMP = 2'd1,
        ST_STEP = 2'd2
    } t_status;

    // register index = paddr[4:3]
    typedef enum logic [1:0] {
        REG_TRICK = 2'd0,
        REG_LIMIT = 2'd1,
        REG_BURST = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

@@ hw/rtl/pjt_if.sv @@
// pjt_in_if / pjt_out_if: valid/ready item channels of the jump tracker.
// Depends on pjt_pkg for field widths and the status type.
`default_nettype none

interface pjt_in_if #(
    parameter int CLOCK_BITS = 34
);
    logic                         valid;
    logic                         ready;
    logic                         is_audio;
    logic                         is_video;
    logic                         pts_present;
    logic [pjt_pkg::PTS_BITS-1:0] pts;
    logic [CLOCK_BITS-1:0]        clock_now;

    modport source (output valid, is_audio, is_video, pts_present, pts, clock_now,
                    input ready);
    modport sink   (input valid, is_audio, is_video, pts_present, pts, clock_now,
                    output ready);
endinterface

interface pjt_out_if;
    logic                         valid;
    logic                         ready;
    pjt_pkg::t_status             status;
    logic [pjt_pkg::PTS_BITS-1:0] elapsed;
    logic                         clock_set;
    logic [pjt_pkg::OUT_BITS-1:0] clock_value;
    logic [pjt_pkg::OUT_BITS-1:0] wait_ticks;

    modport source (output valid, status, elapsed, clock_set, clock_value, wait_ticks,
                    input ready);
    modport sink   (input valid, status, elapsed, clock_set, clock_value, wait_ticks,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pts_jump_tracker.sv @@
// pts_jump_tracker: timestamp discontinuity and clock drift tracker.
// Depends on pjt_pkg and the channel interfaces in pjt_if.sv.
//
//  channel  | dir | handshake          | item
//  ---------+-----+--------------------+------------------------------------------
//  i_in     | in  | valid & ready      | flags, pts, clock_now
//  o_out    | out | valid & ready      | status, elapsed, clock_set/value, wait
//  apb      | in  | psel&penable&pwrite| trick_mode @0x00, jump_limit @0x08,
//           |     |                    | burst_time @0x10 (64-bit data)
//
// Pipeline: two register stages (input, result); one item per clock sustained
//   while the sink takes each result. A result is registered once its item
//   moves from the input stage into the result stage. The stored audio/video
//   times are updated as an item moves into the result register, so the next
//   item in the input register always sees them.
// Reset: synchronous, active low; clears both stage valids, the stored times
//   and restores the configuration defaults.
// Stalls: while the result waits, one more item is held in the input stage;
//   ready drops only when both stages are full and the sink stalls.
`default_nettype none

module pts_jump_tracker #(
    parameter int CLOCK_BITS = 34
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    pjt_in_if.sink                               i_in,
    pjt_out_if.source                            o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pjt_pkg::APB_ABITS-1:0]   paddr,
    input  wire logic [pjt_pkg::APB_DBITS-1:0]   pwdata,
    output logic      [pjt_pkg::APB_DBITS-1:0]   prdata,
    output logic                                 pready
);

    localparam int PB = pjt_pkg::PTS_BITS;
    localparam int OB = pjt_pkg::OUT_BITS;
    localparam int BB = pjt_pkg::BURST_BITS;
    localparam int WX = CLOCK_BITS + 1;   // clock compares with a sign bit

    // ---------------- configuration ----------------
    logic          r_trick;
    logic [PB-1:0] r_limit;
    logic [BB-1:0] r_burst;
    logic          cfg_wr;
    pjt_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = pjt_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trick <= 1'b0;
            r_limit <= pjt_pkg::JUMP_LIMIT_RST;
            r_burst <= pjt_pkg::BURST_TIME_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pjt_pkg::REG_TRICK: r_trick <= pwdata[0];
                pjt_pkg::REG_LIMIT: r_limit <= pwdata[PB-1:0];
                pjt_pkg::REG_BURST: r_burst <= pwdata[BB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            pjt_pkg::REG_TRICK: prdata = {{(pjt_pkg::APB_DBITS-1){1'b0}}, r_trick};
            pjt_pkg::REG_LIMIT: prdata = {{(pjt_pkg::APB_DBITS-PB){1'b0}}, r_limit};
            pjt_pkg::REG_BURST: prdata = {{(pjt_pkg::APB_DBITS-BB){1'b0}}, r_burst};
            default:            prdata = '0;
        endcase
    end

    // ---------------- input stage ----------------
    logic                  r_in_valid;
    logic                  r_audio, r_video, r_present;
    logic [PB-1:0]         r_pts;
    logic [CLOCK_BITS-1:0] r_now;
    logic                  r_out_valid;
    logic                  adv;     // input stage moves to result stage
    logic                  in_acc;

    assign adv        = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready = ~r_in_valid | adv;
    assign in_acc     = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_audio   <= i_in.is_audio;
            r_video   <= i_in.is_video;
            r_present <= i_in.pts_present;
            r_pts     <= i_in.pts;
            r_now     <= i_in.clock_now;
        end
    end

    // ---------------- tracking logic ----------------
    logic [PB-1:0] r_audio_time, r_video_time;
    logic [PB-1:0] cur, d_fwd, d_bwd, abs_step, elapsed;
    logic          usable, fwd, jump, step_pos, drift_chk, drift;
    logic          cset, keep_video;
    logic [PB-1:0] n_audio_time, n_video_time, ref_time;
    logic [WX-1:0] now_x, pts_x, ref_x, drift_d, wait_d, drift_abs;
    logic [OB-1:0] cval, wait_v;
    pjt_pkg::t_status status;

    always_comb begin
        usable   = r_present & (r_pts != '0);
        cur      = r_audio ? r_audio_time : r_video_time;
        d_fwd    = r_pts - cur;
        d_bwd    = cur - r_pts;
        fwd      = (r_pts >= cur);
        abs_step = fwd ? d_fwd : d_bwd;
        jump     = abs_step > r_limit;

        // audio reports |step|; video drops a backward step
        elapsed  = '0;
        if (usable & ~jump) begin
            elapsed = (r_audio | fwd) ? abs_step : '0;
        end
        step_pos = (elapsed != '0);

        // video keeps its time on a small backward step
        keep_video = ~r_audio & ~jump & ~fwd;

        // drift: the tracked time just became pts whenever elapsed > 0
        now_x     = {1'b0, r_now};
        pts_x     = {{(WX-PB){1'b0}}, r_pts};
        drift_d   = now_x - pts_x;
        drift_abs = drift_d[WX-1] ? (pts_x - now_x) : drift_d;
        drift_chk = r_audio | (r_video & r_trick);
        drift     = step_pos & drift_chk & (drift_abs > {{(WX-PB){1'b0}}, r_limit});

        // reference time after this item's update
        if (r_trick) begin
            ref_time = r_audio ? r_video_time : r_pts;
        end else begin
            ref_time = r_audio ? r_pts : r_audio_time;
        end
        ref_x  = {{(WX-PB){1'b0}}, ref_time};
        wait_d = ref_x - now_x;
        wait_v = (step_pos & (ref_x > now_x)) ? wait_d[OB-1:0] : '0;

        cset = usable & ((jump & (r_audio | r_trick)) | drift);
        cval = cset ? ({1'b0, r_pts} + {{(OB-BB){1'b0}}, r_burst}) : '0;

        if (!usable) begin
            status = pjt_pkg::ST_NONE;
        end else if (jump) begin
            status = pjt_pkg::ST_JUMP;
        end else begin
            status = pjt_pkg::ST_STEP;
        end

        n_audio_time = r_audio_time;
        n_video_time = r_video_time;
        if (usable) begin
            if (r_audio) begin
                n_audio_time = r_pts;
            end else if (!keep_video) begin
                n_video_time = r_pts;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_audio_time <= '0;
            r_video_time <= '0;
        end else if (adv) begin
            r_audio_time <= n_audio_time;
            r_video_time <= n_video_time;
        end
    end

    // ---------------- result stage ----------------
    pjt_pkg::t_status r_status;
    logic [PB-1:0]    r_elapsed;
    logic             r_cset;
    logic [OB-1:0]    r_cval, r_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status  <= status;
            r_elapsed <= elapsed;
            r_cset    <= cset;
            r_cval    <= cval;
            r_wait    <= wait_v;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.elapsed     = r_elapsed;
    assign o_out.clock_set   = r_cset;
    assign o_out.clock_value = r_cval;
    assign o_out.wait_ticks  = r_wait;

    // ---------------- checks ----------------
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == pjt_pkg::ST_NONE |->
            r_elapsed == '0 && !r_cset && r_wait == '0)
        else $error("absent timestamp gave a nonzero result field");

    a_jump_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == pjt_pkg::ST_JUMP |-> r_elapsed == '0 && r_wait == '0)
        else $error("jump reset reported elapsed or wait");

    a_cval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_cset |-> r_cval == '0)
        else $error("clock value without a clock load");

    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_audio_time) && $stable(r_video_time))
        else $error("stored time changed without an item");

    a_wait_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_elapsed == '0 |-> r_wait == '0)
        else $error("wait reported on a zero step");

endmodule

`default_nettype wire
